### design/dfs_pkg.sv
// Shared constants, codes and types of the delimited field splitter.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    localparam int MAX_TEXT_LEN = 65536;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN) + 1;
    localparam int BYTE_W       = 8;
    localparam int OFS_W        = 16;
    localparam int CNT_W        = 17;
    localparam int LIMIT_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [BYTE_W-1:0] CHR_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CHR_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIMITER = 1'b0,
        CFG_SEG_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } t_item;

    typedef struct packed {
        logic             has_segment;
        logic [OFS_W-1:0] segment_start;
        logic [OFS_W-1:0] segment_length;
        logic [OFS_W-1:0] segment_index;
        logic             is_final;
        logic [CNT_W-1:0] segment_count;
        logic             length_overflow;
    } t_res;

endpackage

`default_nettype wire

### design/dfs_in_if.sv
// Valid/ready channel that carries one text byte per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface dfs_in_if import dfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

### design/dfs_out_if.sv
// Valid/ready channel that carries one segment result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface dfs_out_if import dfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             has_segment;
    logic [OFS_W-1:0] segment_start;
    logic [OFS_W-1:0] segment_length;
    logic [OFS_W-1:0] segment_index;
    logic             is_final;
    logic [CNT_W-1:0] segment_count;
    logic             length_overflow;

    modport source (
        output valid, output has_segment, output segment_start, output segment_length,
        output segment_index, output is_final, output segment_count,
        output length_overflow, input ready
    );
    modport sink (
        input valid, input has_segment, input segment_start, input segment_length,
        input segment_index, input is_final, input segment_count,
        input length_overflow, output ready
    );
endinterface

`default_nettype wire

### design/dfs_in_reg.sv
// Input register stage of the splitter.
`timescale 1ns / 1ps
`default_nettype none

module dfs_in_reg import dfs_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dfs_in_if.sink      i_text,
    input  wire logic   i_advance,
    output t_item       o_item,
    output logic        o_fire
);

    logic  r_vld;
    logic  n_vld;
    t_item r_item;
    logic  w_ready;

    assign w_ready      = !r_vld || i_advance;
    assign i_text.ready = w_ready;
    assign n_vld        = w_ready ? i_text.valid : r_vld;
    assign o_fire       = r_vld && i_advance;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_text.valid) begin
            r_item.text_byte   <= i_text.text_byte;
            r_item.end_of_text <= i_text.end_of_text;
        end
    end

endmodule

`default_nettype wire

### design/dfs_seg_core.sv
// Configuration registers, per-text state and segment detection logic.
`timescale 1ns / 1ps
`default_nettype none

module dfs_seg_core import dfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire t_item                 i_item,
    input  wire logic                  i_fire,
    output t_res                       o_res,
    output logic                       o_res_vld
);

    logic [BYTE_W-1:0]  r_delim;
    logic [LIMIT_W-1:0] r_limit;

    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_ins,   n_ins;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_lne,   n_lne;
    logic [CNT_W-1:0] r_found, n_found;
    logic             r_ovf,   n_ovf;

    logic             w_blank;
    logic             w_split;
    logic             w_delim;
    logic             w_emit;
    logic [POS_W-1:0] w_seg_start;
    logic [POS_W-1:0] w_seg_len;
    logic [CNT_W-1:0] w_seg_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DELIMITER: r_delim <= i_cfg_wdata[BYTE_W-1:0];
                CFG_SEG_LIMIT: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_blank     = (i_item.text_byte == CHR_SPACE) || (i_item.text_byte == CHR_TAB);
        w_split     = ((CNT_W+1)'(r_found) + (CNT_W+1)'(1)) < (CNT_W+1)'(r_limit);
        w_delim     = w_split && (i_item.text_byte == r_delim);
        w_emit      = 1'b0;
        w_seg_start = '0;
        w_seg_len   = '0;
        w_seg_idx   = r_found;
        n_pos       = r_pos;
        n_ins       = r_ins;
        n_start     = r_start;
        n_lne       = r_lne;
        n_found     = r_found;
        n_ovf       = r_ovf;

        if (r_pos >= POS_W'(MAX_TEXT_LEN)) begin
            n_ovf = 1'b1;
        end else begin
            if (!r_ins) begin
                if (!w_blank) begin
                    if (w_delim) begin
                        w_emit      = 1'b1;
                        w_seg_start = r_pos;
                    end else begin
                        n_ins   = 1'b1;
                        n_start = r_pos;
                        n_lne   = r_pos + POS_W'(1);
                    end
                end
            end else begin
                if (w_delim) begin
                    w_emit      = 1'b1;
                    w_seg_start = r_start;
                    w_seg_len   = r_lne - r_start;
                    n_ins       = 1'b0;
                end else if (!w_blank) begin
                    n_lne = r_pos + POS_W'(1);
                end
            end
            n_pos = r_pos + POS_W'(1);
        end

        // end of text closes an open segment unless this byte already reported one
        if (i_item.end_of_text && !w_emit && n_ins) begin
            w_emit      = 1'b1;
            w_seg_start = n_start;
            w_seg_len   = n_lne - n_start;
        end
        if (w_emit) begin
            n_found = r_found + CNT_W'(1);
        end

        o_res.has_segment     = w_emit;
        o_res.segment_start   = w_emit ? OFS_W'(w_seg_start) : '0;
        o_res.segment_length  = w_emit ? OFS_W'(w_seg_len) : '0;
        o_res.segment_index   = w_emit ? OFS_W'(w_seg_idx) : '0;
        o_res.is_final        = i_item.end_of_text;
        o_res.segment_count   = n_found;
        o_res.length_overflow = n_ovf;
        o_res_vld             = w_emit || i_item.end_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ins   <= 1'b0;
            r_start <= '0;
            r_lne   <= '0;
            r_found <= '0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            if (i_item.end_of_text) begin
                r_pos   <= '0;
                r_ins   <= 1'b0;
                r_start <= '0;
                r_lne   <= '0;
                r_found <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_ins   <= n_ins;
                r_start <= n_start;
                r_lne   <= n_lne;
                r_found <= n_found;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

### design/dfs_out_reg.sv
// Result register stage of the splitter.
`timescale 1ns / 1ps
`default_nettype none

module dfs_out_reg import dfs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_res i_res,
    input  wire logic i_res_vld,
    input  wire logic i_fire,
    output logic      o_advance,
    dfs_out_if.source o_seg
);

    logic r_vld;
    logic n_vld;
    t_res r_res;

    assign o_advance = !r_vld || o_seg.ready;
    assign n_vld     = o_advance ? (i_fire && i_res_vld) : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_seg.valid           = r_vld;
    assign o_seg.has_segment     = r_res.has_segment;
    assign o_seg.segment_start   = r_res.segment_start;
    assign o_seg.segment_length  = r_res.segment_length;
    assign o_seg.segment_index   = r_res.segment_index;
    assign o_seg.is_final        = r_res.is_final;
    assign o_seg.segment_count   = r_res.segment_count;
    assign o_seg.length_overflow = r_res.length_overflow;

endmodule

`default_nettype wire

### design/delimited_field_splitter_top.sv
// Top level of the delimited field splitter.
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte stream into delimiter-separated segments with blanks trimmed, one
// byte per clock as long as o_seg is drained. Every byte taken sits in an input
// register; when the result register can advance, the segment logic updates the
// per-text state and, if the byte closes a segment or ends the text, loads the result
// register. A stalled result register holds off i_text through ready. Delimiter
// and segment limit are written through the config port; the user must write them
// only while idle, which the block does not enforce. The per-text state clears itself
// after the end-of-text byte.
module delimited_field_splitter_top import dfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    dfs_in_if.sink                     i_text,
    dfs_out_if.source                  o_seg
);

    t_item w_item;
    t_res  w_res;
    logic  w_res_vld;
    logic  w_fire;
    logic  w_advance;

    dfs_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_advance (w_advance),
        .o_item    (w_item),
        .o_fire    (w_fire)
    );

    dfs_seg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (w_item),
        .i_fire      (w_fire),
        .o_res       (w_res),
        .o_res_vld   (w_res_vld)
    );

    dfs_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (w_res),
        .i_res_vld (w_res_vld),
        .i_fire    (w_fire),
        .o_advance (w_advance),
        .o_seg     (o_seg)
    );

endmodule

`default_nettype wire

### design/dfs_checker.sv
// Port-level assertions for the splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dfs_checker import dfs_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             i_ready,
    input wire logic             i_has_segment,
    input wire logic [OFS_W-1:0] i_segment_start,
    input wire logic [OFS_W-1:0] i_segment_length,
    input wire logic [OFS_W-1:0] i_segment_index,
    input wire logic             i_is_final,
    input wire logic [CNT_W-1:0] i_segment_count,
    input wire logic             i_length_overflow
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_has_segment) && $stable(i_segment_start)
            && $stable(i_segment_length) && $stable(i_segment_index) && $stable(i_is_final)
            && $stable(i_segment_count) && $stable(i_length_overflow))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_has_segment |-> (i_segment_start == '0) && (i_segment_length == '0)
            && (i_segment_index == '0))
        else $error("empty result carries segment fields");

    a_count_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_has_segment |-> i_segment_count[OFS_W-1:0] == i_segment_index + OFS_W'(1))
        else $error("segment count does not follow index");

    a_mid_has_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_is_final |-> i_has_segment)
        else $error("non-final result without a segment");

endmodule

bind delimited_field_splitter_top dfs_checker u_dfs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_seg.valid),
    .i_ready           (o_seg.ready),
    .i_has_segment     (o_seg.has_segment),
    .i_segment_start   (o_seg.segment_start),
    .i_segment_length  (o_seg.segment_length),
    .i_segment_index   (o_seg.segment_index),
    .i_is_final        (o_seg.is_final),
    .i_segment_count   (o_seg.segment_count),
    .i_length_overflow (o_seg.length_overflow)
);

`default_nettype wire

### tb/sv/tb_delimited_field_splitter_top.sv
// Self-checking testbench of the delimited field splitter: directed table, random texts.
`timescale 1ns / 1ps

module tb_delimited_field_splitter_top;
    import dfs_pkg::*;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [15:0] val;
        logic        eot;
        bit          lit;
        t_res        want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    dfs_in_if  txt ();
    dfs_out_if seg ();

    delimited_field_splitter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_text      (txt),
        .o_seg       (seg)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // splitter state as seen by the checker
    logic [7:0]  cfg_delim = DELIM_RESET;
    logic [15:0] cfg_limit = '0;
    logic [16:0] at_pos    = '0;
    logic        in_field  = 1'b0;
    logic [15:0] field_start = '0;
    logic [16:0] field_end   = '0;
    logic [16:0] found_cnt   = '0;
    logic        ovf_hit     = 1'b0;

    t_res        pending_segs[$];
    int unsigned err_cnt    = 0;
    int unsigned bytes_sent = 0;
    bit          steady     = 1'b0;
    bit          hold_arm   = 1'b0;
    int unsigned hold_left  = 0;

    function automatic void fill_segment(inout t_res r, input logic [16:0] start,
                                         input logic [16:0] len);
        r.has_segment    = 1'b1;
        r.segment_start  = start[15:0];
        r.segment_length = len[15:0];
        r.segment_index  = found_cnt[15:0];
        found_cnt        = found_cnt + 17'd1;
    endfunction

    // returns 1 when the byte produces a result: a segment report or the end of text
    function automatic bit split_byte(input logic [7:0] b, input logic eot, output t_res r);
        bit blank;
        bit delim_hit;
        bit emitted;
        blank   = (b == CHR_SPACE) || (b == CHR_TAB);
        emitted = 1'b0;
        r       = '0;
        if (32'(at_pos) >= MAX_TEXT_LEN) begin
            ovf_hit = 1'b1;
        end else begin
            delim_hit = ((32'(found_cnt) + 32'd1) < 32'(cfg_limit)) && (b == cfg_delim);
            if (!in_field) begin
                if (!blank) begin
                    if (delim_hit) begin
                        fill_segment(r, at_pos, 17'd0);
                        emitted = 1'b1;
                    end else begin
                        in_field    = 1'b1;
                        field_start = at_pos[15:0];
                        field_end   = at_pos + 17'd1;
                    end
                end
            end else if (delim_hit) begin
                fill_segment(r, {1'b0, field_start}, field_end - {1'b0, field_start});
                in_field = 1'b0;
                emitted  = 1'b1;
            end else if (!blank) begin
                field_end = at_pos + 17'd1;
            end
            at_pos = at_pos + 17'd1;
        end
        if (!eot && !emitted)
            return 1'b0;
        if (eot && !emitted && in_field)
            fill_segment(r, {1'b0, field_start}, field_end - {1'b0, field_start});
        r.is_final        = eot;
        r.segment_count   = found_cnt;
        r.length_overflow = ovf_hit;
        if (eot) begin
            at_pos    = '0;
            in_field  = 1'b0;
            field_start = '0;
            field_end = '0;
            found_cnt = '0;
            ovf_hit   = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic string seg_str(input t_res r);
        return $sformatf("seg=%0d start=%0d len=%0d idx=%0d final=%0d count=%0d ovf=%0d",
                         r.has_segment, r.segment_start, r.segment_length, r.segment_index,
                         r.is_final, r.segment_count, r.length_overflow);
    endfunction

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // result side: check each transfer, drive ready
    always @(posedge i_clk) begin : rx_side
        t_res got;
        t_res want;
        if (i_rst_n && seg.valid && seg.ready) begin
            got.has_segment     = seg.has_segment;
            got.segment_start   = seg.segment_start;
            got.segment_length  = seg.segment_length;
            got.segment_index   = seg.segment_index;
            got.is_final        = seg.is_final;
            got.segment_count   = seg.segment_count;
            got.length_overflow = seg.length_overflow;
            if (pending_segs.size() == 0) begin
                note_error({"unexpected result: ", seg_str(got)});
            end else begin
                want = pending_segs.pop_front();
                if (got.has_segment !== want.has_segment ||
                    got.segment_start !== want.segment_start ||
                    got.segment_length !== want.segment_length ||
                    got.segment_index !== want.segment_index ||
                    got.is_final !== want.is_final ||
                    got.segment_count !== want.segment_count ||
                    got.length_overflow !== want.length_overflow)
                    note_error({"mismatch: want ", seg_str(want), " got ", seg_str(got)});
            end
        end
        if (hold_arm) begin
            hold_arm  = 1'b0;
            hold_left = 400;
        end
        if (hold_left != 0) begin
            hold_left--;
            seg.ready <= 1'b0;
        end else begin
            seg.ready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!steady && $urandom_range(99) < 11) begin
            txt.valid <= 1'b0;
            @(posedge i_clk);
        end
        txt.valid       <= 1'b1;
        txt.text_byte   <= b;
        txt.end_of_text <= eot;
        @(posedge i_clk);
        while (!txt.ready) @(posedge i_clk);
    endtask

    task automatic feed(input logic [7:0] b, input logic eot);
        t_res r;
        send_byte(b, eot);
        bytes_sent++;
        if (split_byte(b, eot, r))
            pending_segs.push_back(r);
    endtask

    // one text of words, blanks and delimiters; noise texts take any byte
    task automatic send_text(input bit noise);
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            logic [7:0]  b;
            int unsigned sel;
            sel = $urandom_range(9);
            if (noise || sel >= 5)
                b = 8'($urandom);
            else if (sel < 3)
                b = cfg_delim;
            else
                b = $urandom_range(1) ? CHR_SPACE : CHR_TAB;
            feed(b, i == len - 1);
        end
    endtask

    task automatic settle_idle();
        txt.valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DELIMITER: cfg_delim = val[7:0];
            CFG_SEG_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    function automatic t_stim_row row_byte(input logic [7:0] b, input logic eot);
        t_stim_row row;
        row.kind = ROW_BYTE;
        row.idx  = CFG_DELIMITER;
        row.val  = {8'h00, b};
        row.eot  = eot;
        row.lit  = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_stim_row row_lit(input logic [7:0] b, input logic eot,
                                          input logic has, input logic [15:0] start,
                                          input logic [15:0] len, input logic [15:0] idx,
                                          input logic [16:0] cnt);
        t_stim_row row;
        row      = row_byte(b, eot);
        row.lit  = 1'b1;
        row.want = '{has, start, len, idx, eot, cnt, 1'b0};
        return row;
    endfunction

    function automatic t_stim_row row_cfg(input t_cfg_idx idx, input logic [15:0] val);
        t_stim_row row;
        row      = row_byte(8'h00, 1'b0);
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        return row;
    endfunction

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_stim_row   rows[$];
        t_res        r;
        logic [7:0]  d;
        logic [15:0] lim;
        int unsigned target;
        bit          paused;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DELIMITER;
        i_cfg_wdata     <= '0;
        txt.valid       <= 1'b0;
        txt.text_byte   <= '0;
        txt.end_of_text <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: comma, no splitting
        rows.push_back(row_lit(8'h61, 1'b1, 1'b1, 16'd0, 16'd1, 16'd0, 17'd1));
        rows.push_back(row_lit(CHR_SPACE, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 17'd0));
        rows.push_back(row_byte(DELIM_RESET, 1'b0));
        rows.push_back(row_lit(8'h78, 1'b1, 1'b1, 16'd0, 16'd2, 16'd0, 17'd1));
        rows.push_back(row_cfg(CFG_SEG_LIMIT, 16'd1));
        rows.push_back(row_lit(8'hFF, 1'b1, 1'b1, 16'd0, 16'd1, 16'd0, 17'd1));
        // leading delimiter, trimming, limit reached mid-text
        rows.push_back(row_cfg(CFG_SEG_LIMIT, 16'd3));
        rows.push_back(row_byte(DELIM_RESET, 1'b0));
        rows.push_back(row_byte(CHR_TAB, 1'b0));
        rows.push_back(row_byte(CHR_SPACE, 1'b0));
        rows.push_back(row_byte(8'h62, 1'b0));
        rows.push_back(row_byte(CHR_SPACE, 1'b0));
        rows.push_back(row_byte(DELIM_RESET, 1'b0));
        rows.push_back(row_byte(8'h63, 1'b0));
        rows.push_back(row_byte(DELIM_RESET, 1'b0));
        rows.push_back(row_byte(CHR_SPACE, 1'b1));
        // blank delimiter
        rows.push_back(row_cfg(CFG_DELIMITER, {8'h00, CHR_SPACE}));
        rows.push_back(row_cfg(CFG_SEG_LIMIT, 16'hFFFF));
        rows.push_back(row_byte(CHR_SPACE, 1'b0));
        rows.push_back(row_byte(8'h61, 1'b0));
        rows.push_back(row_byte(CHR_SPACE, 1'b0));
        rows.push_back(row_byte(8'h62, 1'b0));
        rows.push_back(row_byte(CHR_SPACE, 1'b1));
        // empty segments
        rows.push_back(row_cfg(CFG_DELIMITER, 16'h0000));
        rows.push_back(row_lit(8'h00, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 17'd1));
        rows.push_back(row_lit(8'h00, 1'b1, 1'b1, 16'd1, 16'd0, 16'd1, 17'd2));
        rows.push_back(row_cfg(CFG_DELIMITER, 16'h00FF));
        rows.push_back(row_cfg(CFG_SEG_LIMIT, 16'd2));
        rows.push_back(row_byte(8'h71, 1'b0));
        rows.push_back(row_byte(8'hFF, 1'b0));
        rows.push_back(row_byte(8'hFF, 1'b1));
        // trailing blanks after the last delimiter
        rows.push_back(row_cfg(CFG_DELIMITER, {8'h00, DELIM_RESET}));
        rows.push_back(row_cfg(CFG_SEG_LIMIT, 16'hFFFF));
        rows.push_back(row_byte(8'h7A, 1'b0));
        rows.push_back(row_byte(DELIM_RESET, 1'b0));
        rows.push_back(row_lit(CHR_SPACE, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 17'd1));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                settle_idle();
                write_cfg(rows[i].idx, rows[i].val);
            end else begin
                send_byte(rows[i].val[7:0], rows[i].eot);
                if (split_byte(rows[i].val[7:0], rows[i].eot, r) || rows[i].lit)
                    pending_segs.push_back(rows[i].lit ? rows[i].want : r);
            end
        end

        for (int p = 0; p < 8; p++) begin
            settle_idle();
            case (p)
                0: d = DELIM_RESET;
                1: d = CHR_SPACE;
                2: d = CHR_TAB;
                3: d = 8'h00;
                4: d = 8'hFF;
                default: d = 8'($urandom);
            endcase
            case (p)
                0: lim = 16'hFFFF;
                1: lim = 16'd2;
                2: lim = 16'd3;
                3: lim = 16'd1;
                4: lim = 16'd0;
                5: lim = 16'($urandom_range(8, 2));
                6: lim = 16'($urandom);
                default: lim = 16'($urandom_range(5));
            endcase
            write_cfg(CFG_DELIMITER, {8'h00, d});
            write_cfg(CFG_SEG_LIMIT, lim);
            steady = (p == 5);
            if (p == 2)
                hold_arm = 1'b1;
            target = bytes_sent + 100;
            paused = 1'b0;
            while (bytes_sent < target) begin
                send_text($urandom_range(99) < 15);
                if (p == 3 && !paused && bytes_sent + 50 >= target) begin
                    settle_idle();
                    paused = 1'b1;
                end
            end
        end

        txt.valid <= 1'b0;
        steady = 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        err_cnt += pending_segs.size();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
